// ===== rtl/core/mvf_pkg.sv =====
// ----------------------------------------------------------------------------
// mvf_pkg
// shared widths and control structs for the majority vote filter
// ----------------------------------------------------------------------------
package mvf_pkg;

  localparam int unsigned EntityIdW = 6;
  localparam int unsigned LabelW    = 5;

  // commands from the sequencer to the histogram unit
  typedef struct packed {
    logic              clear;
    logic              inc;
    logic [LabelW-1:0] inc_label;
    logic              scan_start;
  } hist_ctrl_t;

  // status back from the histogram unit
  typedef struct packed {
    logic              done;
    logic [LabelW-1:0] best_label;
  } hist_sts_t;

endpackage

// ===== rtl/core/mvf_ram.sv =====
// ----------------------------------------------------------------------------
// mvf_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mvf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mvf_hist.sv =====
// ----------------------------------------------------------------------------
// mvf_hist
// label histogram with a one bin per cycle scan for the most frequent label
// ----------------------------------------------------------------------------
module mvf_hist
  import mvf_pkg::*;
#(
  parameter int unsigned NUM_BINS = 21,
  parameter int unsigned CNT_W    = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hist_ctrl_t ctrl_i,
  output hist_sts_t  sts_o
);

  localparam int unsigned BinW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [BinW-1:0] BinLast = BinW'(NUM_BINS - 1);

  logic [CNT_W-1:0] hist_q [NUM_BINS];
  logic [BinW-1:0]  hidx;
  logic [CNT_W-1:0] bin_rd;

  logic             scanning_q;
  logic [BinW-1:0]  sc_q;
  logic             done_q;
  logic [BinW-1:0]  best_q;
  logic [CNT_W-1:0] best_cnt_q;

  // one read port: scan index while scanning, incoming label otherwise
  assign hidx   = scanning_q ? sc_q : ctrl_i.inc_label[BinW-1:0];
  assign bin_rd = hist_q[hidx];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        hist_q[b] <= '0;
      end
    end else if (ctrl_i.inc && !scanning_q) begin
      hist_q[hidx] <= bin_rd + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q <= 1'b0;
      sc_q       <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.scan_start) begin
        scanning_q <= 1'b1;
        sc_q       <= '0;
      end else if (scanning_q) begin
        if (sc_q == BinLast) begin
          scanning_q <= 1'b0;
          done_q     <= 1'b1;
        end else begin
          sc_q <= sc_q + BinW'(1);
        end
      end
    end
  end

  // strict compare in ascending order keeps the lowest label on ties
  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_start) begin
      best_q     <= '0;
      best_cnt_q <= '0;
    end else if (scanning_q && (bin_rd > best_cnt_q)) begin
      best_q     <= sc_q;
      best_cnt_q <= bin_rd;
    end
  end

  assign sts_o.done       = done_q;
  assign sts_o.best_label = LabelW'(best_q);

endmodule

// ===== rtl/core/per_entity_majority_vote_filter.sv =====
// flow: the first beat of an entity goes from ST_META straight to ST_FINISH, otherwise
//   ST_RING reads the filled ring slots and ST_SCAN scans min(CLASSES,32) bins first
// items: one at a time, in_stall_o stays high until the result is loaded into the
//   output register, held up by the ring read walk, the histogram scan and out_stall_i
// reset: a clearing pass writes every entry of the entity state ram while in_stall_o
//   stays high; label ring contents are left as they are
// ----------------------------------------------------------------------------
// per_entity_majority_vote_filter
// per entity sliding window of labels, returns the most frequent label
// ----------------------------------------------------------------------------
module per_entity_majority_vote_filter
  import mvf_pkg::*;
#(
  parameter int unsigned ENTITIES = 64,
  parameter int unsigned WINDOW   = 10,
  parameter int unsigned CLASSES  = 21
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [EntityIdW-1:0] entity_id_i,
  input  logic [LabelW-1:0] raw_label_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LabelW-1:0] smoothed_label_o
);

  localparam int unsigned EntW   = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;
  localparam int unsigned Slots  = ENTITIES * WINDOW;
  localparam int unsigned RingAw = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned FillW  = $clog2(WINDOW + 1);
  localparam int unsigned PosW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned MetaW  = 1 + FillW + PosW;
  localparam int unsigned NumBins = (CLASSES > 32) ? 32 : CLASSES;
  localparam int unsigned IdRange = 2 ** EntityIdW;

  localparam logic [EntW-1:0]   EntLast  = EntW'(ENTITIES - 1);
  localparam logic [RingAw-1:0] WinA     = RingAw'(WINDOW);
  localparam logic [FillW-1:0]  WinFill  = FillW'(WINDOW);
  localparam logic [PosW-1:0]   PosLast  = PosW'(WINDOW - 1);
  localparam logic [PosW-1:0]   PosOne   = (WINDOW > 1) ? PosW'(1) : '0;
  localparam logic [LabelW-1:0] LabelMax = LabelW'(NumBins - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_RING,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [EntW-1:0]   clr_q, clr_d;
  logic [RingAw-1:0] base_q, base_d;
  logic [LabelW-1:0] label_q, label_d;
  logic [FillW-1:0]  n_q, n_d;
  logic [FillW-1:0]  idx_q, idx_d;
  logic              rv_q, rv_d;
  logic [LabelW-1:0] result_q, result_d;
  logic              out_valid_q, out_valid_d;
  logic [LabelW-1:0] out_label_q, out_label_d;

  logic [EntW-1:0]   ent_wrap_lut [IdRange];
  logic [EntW-1:0]   ent_wrap;
  logic [LabelW-1:0] label_sat;

  logic              meta_we;
  logic [EntW-1:0]   meta_waddr;
  logic [MetaW-1:0]  meta_wdata;
  logic [MetaW-1:0]  meta_rdata;
  logic              meta_seen;
  logic [FillW-1:0]  meta_fill;
  logic [PosW-1:0]   meta_pos;
  logic [FillW-1:0]  fill_new;
  logic [PosW-1:0]   pos_new;

  logic              ring_we;
  logic [RingAw-1:0] ring_waddr;
  logic [RingAw-1:0] ring_raddr;
  logic [LabelW-1:0] ring_rdata;

  hist_ctrl_t hist_ctrl;
  hist_sts_t  hist_sts;

  // entity index wrap, worked out at elaboration
  for (genvar g = 0; g < IdRange; g++) begin : g_ent_wrap
    localparam int unsigned Wrapped = g % ENTITIES;
    assign ent_wrap_lut[g] = Wrapped[EntW-1:0];
  end

  assign ent_wrap  = ent_wrap_lut[entity_id_i];
  assign label_sat = (raw_label_i > LabelMax) ? LabelMax : raw_label_i;

  assign meta_seen = meta_rdata[MetaW-1];
  assign meta_fill = meta_rdata[PosW +: FillW];
  assign meta_pos  = meta_rdata[PosW-1:0];
  assign fill_new  = (meta_fill < WinFill) ? meta_fill + FillW'(1) : meta_fill;
  assign pos_new   = (meta_pos == PosLast) ? '0 : meta_pos + PosW'(1);

  mvf_ram #(
    .WIDTH (MetaW),
    .DEPTH (ENTITIES)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (ent_wrap),
    .rdata_o (meta_rdata)
  );

  mvf_ram #(
    .WIDTH (LabelW),
    .DEPTH (Slots)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (label_q),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  mvf_hist #(
    .NUM_BINS (NumBins),
    .CNT_W    (FillW)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hist_ctrl),
    .sts_o  (hist_sts)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    base_d      = base_q;
    label_d     = label_q;
    n_d         = n_q;
    idx_d       = idx_q;
    rv_d        = 1'b0;
    result_d    = result_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_label_d = out_label_q;

    meta_we    = 1'b0;
    meta_waddr = clr_q;
    meta_wdata = '0;
    ring_we    = 1'b0;
    ring_waddr = base_q;
    ring_raddr = base_q + RingAw'(idx_q);

    hist_ctrl            = '0;
    hist_ctrl.inc        = rv_q;
    hist_ctrl.inc_label  = ring_rdata;

    unique case (state_q)
      ST_CLEAR: begin
        meta_we = 1'b1;
        if (clr_q == EntLast) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + EntW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          clr_d   = ent_wrap;
          base_d  = RingAw'(ent_wrap) * WinA;
          label_d = label_sat;
          state_d = ST_META;
        end
      end
      ST_META: begin
        meta_we = 1'b1;
        ring_we = 1'b1;
        if (!meta_seen) begin
          // first beat of this entity: fresh ring holding only this label
          meta_wdata = {1'b1, FillW'(1), PosOne};
          result_d   = label_q;
          state_d    = ST_FINISH;
        end else begin
          ring_waddr      = base_q + RingAw'(meta_pos);
          meta_wdata      = {1'b1, fill_new, pos_new};
          n_d             = fill_new;
          idx_d           = '0;
          hist_ctrl.clear = 1'b1;
          state_d         = ST_RING;
        end
      end
      ST_RING: begin
        if (idx_q != n_q) begin
          rv_d  = 1'b1;
          idx_d = idx_q + FillW'(1);
        end else if (!rv_q) begin
          hist_ctrl.scan_start = 1'b1;
          state_d              = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hist_sts.done) begin
          result_d = hist_sts.best_label;
          state_d  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_label_d = result_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    label_q     <= label_d;
    result_q    <= result_d;
    out_label_q <= out_label_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign smoothed_label_o = out_label_q;

`ifndef SYNTHESIS
  a_accept_to_meta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_META))
    else $error("accepted beat did not start a state lookup");

  a_ring_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RING) |-> (idx_q <= n_q) && (n_q != '0) && (n_q <= WinFill))
    else $error("ring walk out of fill range");

  a_hist_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_sts.done |-> (state_q == ST_SCAN))
    else $error("histogram scan finished outside scan state");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && !(out_valid_q && out_stall_i))
      |=> out_valid_o && (smoothed_label_o == $past(result_q)))
    else $error("finished result not loaded into output register");
`endif

endmodule
